// File: rtl/core/neel_pkg.sv
`default_nettype none
package neel_pkg;
  localparam int MaxShells = 4;
  localparam int CoordBits = 24;
  localparam int ShellIdxBits = $clog2(MaxShells);
  localparam logic [23:0] RatioMax = 24'hFFFFFF;
  localparam logic [2:0] AddrCenterX = 3'd0;
  localparam logic [2:0] AddrCenterY = 3'd1;
  localparam logic [2:0] AddrCenterZ = 3'd2;
  localparam logic [2:0] AddrShellCnt = 3'd3;

  typedef struct packed {
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    logic signed [CoordBits-1:0] query_z;
  } query_t;

  typedef struct packed {
    logic [31:0] edge_limit;
    logic        beyond_outer;
    logic [1:0]  zone_index;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/core/neel_stream_if.sv
`default_nettype none
interface neel_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/nested_ellipsoid_edge_length_top.sv
// Channel  | Direction | Payload
// query    | in        | query_x, query_y, query_z (24-bit signed each)
// result   | out       | edge_limit (32), beyond_outer (1), zone_index (2)
// apb      | in        | eight registers at 8*i, 64-bit data
// The time from acceptance to a valid result is set by the single shared
// divide/root unit. Each shell test runs three restoring divisions over 40, 40 and
// 56 dividend bits, each skipped when its ratio saturates.
// Up to five shell tests run, and the interpolation adds two square roots over 50
// radicand bits, a ratio division over 40 dividend bits and one over 64 dividend bits.
// Reset clears the registers to their reset values and the sequencer to idle.
// The block accepts no item while one is at work or its result waits.
`default_nettype none
module nested_ellipsoid_edge_length_top
  import neel_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  neel_stream_if.sink   query_i,
  neel_stream_if.source result_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  typedef enum logic [4:0] {
    S_IDLE, S_TEST, S_DX, S_DY, S_DZ, S_SUM, S_DECIDE, S_ROOTV,
    S_RATIO, S_ROOTW, S_DIVIDE, S_FINISH, S_OUT
  } state_e;

  // Configuration registers.
  logic signed [CoordBits-1:0] cx_q, cy_q, cz_q;
  logic [2:0] cnt_q;
  logic [63:0] sw_q [MaxShells];

  assign pready = 1'b1;
  wire [2:0] ridx = paddr[5:3];
  always_comb begin
    case (ridx)
      AddrCenterX:  prdata = 64'({{(64-CoordBits){cx_q[CoordBits-1]}}, cx_q} & 64'hFFFFFF);
      AddrCenterY:  prdata = 64'({{(64-CoordBits){cy_q[CoordBits-1]}}, cy_q} & 64'hFFFFFF);
      AddrCenterZ:  prdata = 64'({{(64-CoordBits){cz_q[CoordBits-1]}}, cz_q} & 64'hFFFFFF);
      AddrShellCnt: prdata = {61'd0, cnt_q};
      default:      prdata = sw_q[ridx[1:0]];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0; cnt_q <= 3'd1;
      for (int k = 0; k < MaxShells; k++) sw_q[k] <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        AddrCenterX:  cx_q <= pwdata[CoordBits-1:0];
        AddrCenterY:  cy_q <= pwdata[CoordBits-1:0];
        AddrCenterZ:  cz_q <= pwdata[CoordBits-1:0];
        AddrShellCnt: cnt_q <= pwdata[2:0];
        default:      sw_q[ridx[1:0]] <= pwdata;
      endcase
    end
  end

  // Sequencer state and datapath registers.
  state_e state_q;
  logic [24:0] ax_q, ay_q, az_q;   // axis distances (up to 2^24-1)
  logic [1:0]  n_q;                // effective shell count minus one
  logic [1:0]  sh_q;               // shell under test
  logic [1:0]  phase_q;            // 0 inner,1 outer,2 walk
  logic [23:0] qx_q, qy_q, qz_q;
  logic [49:0] s_q;                // squared norm Q18.32
  logic [23:0] v_q, w_q;
  logic [31:0] res_q;
  logic        beyond_q;
  logic [1:0]  zone_q;
  // Shared restoring divide / root unit.
  logic [63:0] num_q;              // dividend or radicand shifting register
  logic [63:0] rem_q;
  logic [63:0] quo_q;
  logic [63:0] den_q;
  logic [6:0]  step_q;
  logic        neg_q;
  logic signed [24:0] dl_q;        // length step between the two shells
  logic signed [49:0] prod_q;      // interpolation numerator

  assign query_i.ready = (state_q == S_IDLE);
  assign result_o.valid = (state_q == S_OUT);
  assign result_o.data = '{edge_limit: res_q, beyond_outer: beyond_q, zone_index: zone_q};

  wire [63:0] cur_w = sw_q[sh_q];
  wire [63:0] nxt_w = sw_q[sh_q + 2'd1];
  wire [23:0] cur_r = cur_w[23:0];
  wire [16:0] cur_k = 17'd65536 - {1'b0, cur_w[63:48]};
  wire [40:0] rk = 41'(cur_r) * 41'(cur_k);

  function automatic logic [24:0] absd(input logic signed [CoordBits-1:0] a,
                                       input logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] d;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    return d[CoordBits] ? 25'(-d) : 25'(d);
  endfunction

  // One restoring division step (dividend bits enter from num_q MSB).
  wire [64:0] rem_sh = {rem_q, num_q[63]};
  wire        fits = rem_sh >= {1'b0, den_q};
  // One square-root step on two radicand bits.
  wire [65:0] rrem_sh = {rem_q, num_q[63:62]};
  wire [65:0] rtrial = {quo_q, 2'b01};
  wire        rfits = rrem_sh >= rtrial;

  wire [23:0] lcur = cur_w[47:24];
  // Inner length plus the signed quotient, before saturation.
  wire signed [65:0] fin_sum = $signed({42'd0, lcur}) +
      (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
  wire signed [24:0] vm = $signed({1'b0, v_q}) - 25'sd65536;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q <= '0; ay_q <= '0; az_q <= '0;
      n_q <= '0; sh_q <= '0; phase_q <= '0;
      qx_q <= '0; qy_q <= '0; qz_q <= '0;
      s_q <= '0; v_q <= '0; w_q <= '0;
      res_q <= '0; beyond_q <= 1'b0; zone_q <= '0;
      num_q <= '0; rem_q <= '0; quo_q <= '0; den_q <= '0;
      step_q <= '0; neg_q <= 1'b0; dl_q <= '0; prod_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (query_i.valid) begin
          ax_q <= absd(query_i.data.query_x, cx_q);
          ay_q <= absd(query_i.data.query_y, cy_q);
          az_q <= absd(query_i.data.query_z, cz_q);
          n_q <= (cnt_q == 3'd0) ? 2'd0 : (cnt_q > 3'(MaxShells)) ? 2'(MaxShells-1)
                 : 2'(cnt_q - 3'd1);
          sh_q <= 2'd0; phase_q <= 2'd0;
          state_q <= S_TEST;
        end
        S_TEST: begin
          // Start x ratio: |dx|<<16 / r over 40 dividend bits.
          if (cur_r == 0 || 32'(ax_q) >= {cur_r, 8'd0}) begin
            quo_q <= 64'(RatioMax); step_q <= 7'd0; state_q <= S_DX;
          end else begin
            num_q <= {ax_q[23:0], 16'd0, 24'd0}; rem_q <= '0; quo_q <= '0;
            den_q <= 64'(cur_r); step_q <= 7'd40; state_q <= S_DX;
          end
        end
        S_DX, S_DY, S_DZ: begin
          if (step_q != 0) begin
            rem_q <= fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
            quo_q <= {quo_q[62:0], fits};
            num_q <= {num_q[62:0], 1'b0};
            step_q <= step_q - 7'd1;
          end else if (state_q == S_DX) begin
            qx_q <= quo_q[23:0];
            if (cur_r == 0 || 33'(ay_q) >= {cur_r, 8'd0}) begin
              quo_q <= 64'(RatioMax); step_q <= 7'd0; state_q <= S_DY;
            end else begin
              num_q <= {ay_q[23:0], 16'd0, 24'd0}; rem_q <= '0; quo_q <= '0;
              den_q <= 64'(cur_r); step_q <= 7'd40; state_q <= S_DY;
            end
          end else if (state_q == S_DY) begin
            qy_q <= quo_q[23:0];
            // The z ratio uses the polar semi-axis r*k over 56 dividend bits.
            if (rk == 0 || 49'({az_q, 8'd0}) >= 49'(rk)) begin
              qz_q <= RatioMax; state_q <= S_SUM;
            end else begin
              num_q <= {az_q[23:0], 32'd0, 8'd0}; rem_q <= '0; quo_q <= '0;
              den_q <= 64'(rk); step_q <= 7'd56; state_q <= S_DZ;
            end
          end else begin
            qz_q <= quo_q[23:0]; state_q <= S_SUM;
          end
        end
        S_SUM: begin
          s_q <= 50'(48'(qx_q) * 48'(qx_q)) + 50'(48'(qy_q) * 48'(qy_q))
               + 50'(48'(qz_q) * 48'(qz_q));
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          case (phase_q)
            2'd0: if (s_q <= 50'h1_0000_0000) begin
              res_q <= 32'(lcur); beyond_q <= 1'b0; zone_q <= 2'd0; state_q <= S_OUT;
            end else if (n_q == 2'd0) begin
              res_q <= '1; beyond_q <= 1'b1; zone_q <= 2'd0; state_q <= S_OUT;
            end else begin
              phase_q <= 2'd1; sh_q <= n_q; state_q <= S_TEST;
            end
            2'd1: if (s_q > 50'h1_0000_0000) begin
              res_q <= '1; beyond_q <= 1'b1; zone_q <= 2'd0; state_q <= S_OUT;
            end else begin
              phase_q <= 2'd2; sh_q <= n_q - 2'd1; state_q <= S_TEST;
            end
            default: if (sh_q != 2'd0 && s_q <= 50'h1_0000_0000) begin
              sh_q <= sh_q - 2'd1; state_q <= S_TEST;
            end else begin
              // s_q now belongs to the inner shell of the zone, sh_q.
              num_q <= {s_q, 14'd0}; rem_q <= '0; quo_q <= '0;
              step_q <= 7'd25; state_q <= S_ROOTV;
            end
          endcase
        end
        S_ROOTV, S_ROOTW: begin
          if (step_q != 0) begin
            rem_q <= rfits ? 64'(rrem_sh - rtrial) : rrem_sh[63:0];
            quo_q <= {quo_q[62:0], rfits};
            num_q <= {num_q[61:0], 2'b00};
            step_q <= step_q - 7'd1;
          end else if (state_q == S_ROOTV) begin
            v_q <= (quo_q > 64'(RatioMax)) ? RatioMax : quo_q[23:0];
            if (cur_r == 0 || 32'(nxt_w[23:0]) >= {cur_r, 8'd0}) begin
              quo_q <= 64'(RatioMax); step_q <= 7'd0; state_q <= S_RATIO;
            end else begin
              num_q <= {nxt_w[23:0], 16'd0, 24'd0}; rem_q <= '0; quo_q <= '0;
              den_q <= 64'(cur_r); step_q <= 7'd40; state_q <= S_RATIO;
            end
          end else begin
            w_q <= (quo_q > 64'(RatioMax)) ? RatioMax : quo_q[23:0];
            dl_q <= $signed({1'b0, nxt_w[47:24]}) - $signed({1'b0, lcur});
            state_q <= S_FINISH; step_q <= 7'd0;
          end
        end
        S_RATIO: begin
          if (step_q != 0) begin
            rem_q <= fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
            quo_q <= {quo_q[62:0], fits};
            num_q <= {num_q[62:0], 1'b0};
            step_q <= step_q - 7'd1;
          end else begin
            num_q <= 64'(50'd3 * 50'(48'(quo_q[23:0]) * 48'(quo_q[23:0]))) << 14;
            rem_q <= '0; quo_q <= '0; step_q <= 7'd25; state_q <= S_ROOTW;
          end
        end
        S_FINISH: begin
          if (step_q == 0) begin
            // num = dL * (v - 1), den = w - 1; magnitudes go into the divider.
            prod_q <= 50'(dl_q * vm);
            step_q <= 7'd1;
          end else begin
            if (w_q == 24'd65536) begin
              res_q <= (prod_q > 0) ? '1 : (prod_q < 0) ? 32'd0 : 32'(lcur);
              beyond_q <= 1'b0; zone_q <= sh_q; state_q <= S_OUT;
            end else begin
              neg_q <= prod_q[49] ^ (w_q < 24'd65536);
              num_q <= prod_q[49] ? 64'(-prod_q) : 64'(prod_q);
              den_q <= (w_q < 24'd65536) ? 64'(24'd65536 - w_q) : 64'(w_q - 24'd65536);
              rem_q <= '0; quo_q <= '0; step_q <= 7'd64; state_q <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (step_q != 0) begin
            rem_q <= fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
            quo_q <= {quo_q[62:0], fits};
            num_q <= {num_q[62:0], 1'b0};
            step_q <= step_q - 7'd1;
          end else begin
            res_q <= fin_sum[65] ? 32'd0 : (|fin_sum[64:32]) ? '1 : fin_sum[31:0];
            beyond_q <= 1'b0; zone_q <= sh_q; state_q <= S_OUT;
          end
        end
        S_OUT: if (result_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !query_i.ready) else $error("ready while busy");
  a_outer_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.beyond_outer) |-> (result_o.data.edge_limit == '1))
    else $error("outer flag without saturation");
  a_outer_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.beyond_outer) |-> (result_o.data.zone_index == 2'd0))
    else $error("outer flag with zone");
`endif
endmodule
`default_nettype wire

// File: tb/tb_nested_ellipsoid_edge_length_top.sv
`default_nettype none
module tb_nested_ellipsoid_edge_length_top
  import neel_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Register map: eight 64-bit registers at byte address 8*i.
  localparam logic [2:0] RegShell0 = 3'd4;
  localparam int NumRandom = 1700;

  // The scoreboard holds the expected edge limits, oldest first, and
  // counts any mismatches against the results that come out of the block.
  class edge_limit_board;
    result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_query(result_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(result_t got);
      result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result edge_limit=%0d", got.edge_limit);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.edge_limit !== exp_res.edge_limit) begin
        $error("edge_limit expected %0d got %0d", exp_res.edge_limit, got.edge_limit);
        errors++;
      end
      if (got.beyond_outer !== exp_res.beyond_outer) begin
        $error("beyond_outer expected %0d got %0d", exp_res.beyond_outer,
               got.beyond_outer);
        errors++;
      end
      if (got.zone_index !== exp_res.zone_index) begin
        $error("zone_index expected %0d got %0d", exp_res.zone_index, got.zone_index);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  neel_stream_if #(.payload_t(query_t)) query_ch ();
  neel_stream_if #(.payload_t(result_t)) result_ch ();

  nested_ellipsoid_edge_length_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .query_i  (query_ch.sink),
    .result_o (result_ch.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // The testbench keeps its own copy of the register file for prediction.
  logic signed [CoordBits-1:0] mdl_centre[3];
  logic [2:0] mdl_count;
  logic [63:0] mdl_shell[MaxShells];

  edge_limit_board board = new();
  bit hold_results = 1'b0;

  // Axis ratio in Q8.16, floored and saturated; a zero divisor saturates too.
  function automatic logic [63:0] axis_ratio(logic [63:0] mag, logic [63:0] den,
                                             bit wide);
    if (den == 0) return 64'hFFFFFF;
    if (!wide) begin
      if (mag >= (den << 8)) return 64'hFFFFFF;
      return (mag << 16) / den;
    end
    if ((mag << 8) >= den) return 64'hFFFFFF;
    return (mag << 32) / den;
  endfunction

  function automatic logic [63:0] shell_norm(int idx, logic [63:0] ax, logic [63:0] ay,
                                             logic [63:0] az);
    logic [63:0] rad, kq, rx, ry, rz;
    rad = {40'd0, mdl_shell[idx][23:0]};
    kq = 64'd65536 - {48'd0, mdl_shell[idx][63:48]};
    rx = axis_ratio(ax, rad, 1'b0);
    ry = axis_ratio(ay, rad, 1'b0);
    rz = axis_ratio(az, rad * kq, 1'b1);
    return rx * rx + ry * ry + rz * rz;
  endfunction

  function automatic logic [63:0] root_q(logic [63:0] val);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv >>= 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return (res > 64'hFFFFFF) ? 64'hFFFFFF : res;
  endfunction

  function automatic result_t predict_edge(query_t q);
    result_t r;
    logic signed [63:0] dx, dy, dz, num, den, res, li, lj;
    logic [63:0] ax, ay, az, vq, wq, rq;
    logic [63:0] one2;
    int n, i;
    one2 = 64'd1 << 32;
    dx = 64'(q.query_x) - 64'(mdl_centre[0]);
    dy = 64'(q.query_y) - 64'(mdl_centre[1]);
    dz = 64'(q.query_z) - 64'(mdl_centre[2]);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    n = mdl_count;
    if (n == 0) n = 1;
    if (n > MaxShells) n = MaxShells;
    r = '0;
    if (shell_norm(0, ax, ay, az) <= one2) begin
      r.edge_limit = {8'd0, mdl_shell[0][47:24]};
      return r;
    end
    if (n == 1 || shell_norm(n - 1, ax, ay, az) > one2) begin
      r.edge_limit = '1;
      r.beyond_outer = 1'b1;
      return r;
    end
    i = n - 2;
    while (i >= 1 && shell_norm(i, ax, ay, az) <= one2) i--;
    vq = root_q(shell_norm(i, ax, ay, az));
    rq = axis_ratio({40'd0, mdl_shell[i+1][23:0]}, {40'd0, mdl_shell[i][23:0]}, 1'b0);
    wq = root_q(3 * rq * rq);
    li = {40'd0, mdl_shell[i][47:24]};
    lj = {40'd0, mdl_shell[i+1][47:24]};
    num = (lj - li) * ($signed(vq) - 64'sd65536);
    den = $signed(wq) - 64'sd65536;
    if (den == 0) res = num > 0 ? 64'sd4294967295 : (num < 0 ? 64'sd0 : li);
    else res = li + num / den;
    if (res < 0) res = 0;
    if (res > 64'sd4294967295) res = 64'sd4294967295;
    r.edge_limit = res[31:0];
    r.zone_index = i[1:0];
    return r;
  endfunction

  // One APB write: setup cycle, then access cycle, with the model updated alike.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      AddrCenterX: mdl_centre[0] = val[CoordBits-1:0];
      AddrCenterY: mdl_centre[1] = val[CoordBits-1:0];
      AddrCenterZ: mdl_centre[2] = val[CoordBits-1:0];
      AddrShellCnt: mdl_count = val[2:0];
      default: mdl_shell[idx - RegShell0] = val;
    endcase
  endtask

  // Withdraws the offer and waits until every result has come home.
  task automatic wait_drained();
    query_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Offer one query after a random gap; the prediction is noted on acceptance.
  // With no gap the offer stays up and only the payload moves on.
  task automatic send_query(query_t q, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      query_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    query_ch.valid <= 1'b1;
    query_ch.data <= q;
    @(posedge clk_i);
    while (!query_ch.ready) @(posedge clk_i);
    board.note_query(predict_edge(q));
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] make_shell(logic [23:0] rad, logic [23:0] len,
                                             logic [15:0] obl);
    return {obl, len, rad};
  endfunction

  // Query placed near the centre at a scale that lands around the shells.
  function automatic query_t near_query(int scale);
    query_t q;
    q.query_x = CoordBits'(mdl_centre[0] + $signed($urandom_range(0, 2 * scale)) - scale);
    q.query_y = CoordBits'(mdl_centre[1] + $signed($urandom_range(0, 2 * scale)) - scale);
    q.query_z = CoordBits'(mdl_centre[2] + $signed($urandom_range(0, 2 * scale)) - scale);
    return q;
  endfunction

  function automatic query_t raw_query();
    query_t q;
    q.query_x = CoordBits'($urandom());
    q.query_y = CoordBits'($urandom());
    q.query_z = CoordBits'($urandom());
    return q;
  endfunction

  // A random but mostly ordered set of shells, written while the block is idle.
  task automatic random_setting(bit extreme);
    logic [23:0] rad, len;
    rad = 24'($urandom_range(1, 3000));
    len = 24'($urandom_range(1, 1000));
    write_reg(AddrCenterX, extreme ? 64'h800000 : 64'($signed(24'($urandom))));
    write_reg(AddrCenterY, extreme ? 64'h7FFFFF : 64'($urandom_range(0, 2000)));
    write_reg(AddrCenterZ, 64'($urandom));
    write_reg(AddrShellCnt, 64'($urandom_range(0, 7)));
    for (int s = 0; s < MaxShells; s++) begin
      if ($urandom_range(0, 5) == 0)
        write_reg(RegShell0 + 3'(s), {$urandom, $urandom});
      else
        write_reg(RegShell0 + 3'(s),
                  make_shell(rad, len, 16'($urandom_range(0, 3) == 0 ? $urandom : 0)));
      rad = 24'(rad + $urandom_range(1, 4000));
      len = 24'(len + $urandom_range(0, 2000));
    end
  endtask

  // The result side stalls at random and, when asked, holds off entirely.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        result_ch.ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (stall != 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready)
      board.check_result(result_ch.data);
  end

  initial begin
    query_t q;
    query_ch.valid = 1'b0;
    query_ch.data = '0;
    mdl_centre[0] = 0; mdl_centre[1] = 0; mdl_centre[2] = 0;
    mdl_count = 3'd1;
    for (int s = 0; s < MaxShells; s++) mdl_shell[s] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting: a zero radius, so every off-centre point lies outside.
    q = '0;
    send_query(q, 1'b0);
    q.query_x = 24'sh7FFFFF; q.query_y = -24'sh800000; q.query_z = 24'sh000001;
    send_query(q, 1'b0);
    wait_drained();

    // Directed: four ordered shells, with oblateness, and points from the centre out past the outer shell.
    write_reg(AddrCenterX, 64'd100);
    write_reg(AddrCenterY, -64'sd50);
    write_reg(AddrCenterZ, 64'd0);
    write_reg(AddrShellCnt, 64'd4);
    write_reg(RegShell0, make_shell(24'd100, 24'd10, 16'd0));
    write_reg(RegShell0 + 3'd1, make_shell(24'd400, 24'd50, 16'h8000));
    write_reg(RegShell0 + 3'd2, make_shell(24'd1600, 24'd300, 16'hFFFF));
    write_reg(RegShell0 + 3'd3, make_shell(24'd6400, 24'hFFFFFF, 16'd0));
    for (int k = 0; k < 12; k++) begin
      q.query_x = 24'(100 + k * 600); q.query_y = -24'sd50; q.query_z = 24'(k * 3);
      send_query(q, 1'b0);
    end
    q.query_x = 24'sh7FFFFF; q.query_y = 24'sh7FFFFF; q.query_z = 24'sh7FFFFF;
    send_query(q, 1'b0);
    q.query_x = -24'sh800000; q.query_y = -24'sh800000; q.query_z = -24'sh800000;
    send_query(q, 1'b0);
    wait_drained();

    // Unordered shells, equal radii (zero span) and count above the maximum.
    write_reg(AddrShellCnt, 64'd7);
    write_reg(RegShell0 + 3'd1, make_shell(24'd100, 24'd5, 16'd0));
    write_reg(RegShell0 + 3'd2, make_shell(24'd58, 24'd900, 16'd0));
    for (int k = 0; k < 6; k++) begin
      q.query_x = 24'(100 + 60 + k * 200); q.query_y = -24'sd50; q.query_z = '0;
      send_query(q, 1'b0);
    end
    wait_drained();

    // Random phases; each ends drained so the next setting is written idle.
    for (int ph = 0; ph < 8; ph++) begin
      random_setting(ph == 0 || ph == 7);
      for (int k = 0; k < NumRandom / 8; k++) begin
        if ($urandom_range(0, 9) == 0) q = raw_query();
        else q = near_query(int'(mdl_shell[$urandom_range(0, 3)][23:0]) * 2 + 2);
        send_query(q, ($urandom_range(0, 4) != 0));
        // The sender pauses once for every result to come home.
        if (ph == 2 && k == 50) wait_drained();
        // Long hold-off on the receiver so the input stalls behind it.
        if (ph == 3 && k == 20) begin
          fork
            begin
              hold_results = 1'b1;
              repeat (3000) @(posedge clk_i);
              hold_results = 1'b0;
            end
          join_none
        end
      end
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/core/neel_pkg.sv
rtl/core/neel_stream_if.sv
rtl/core/nested_ellipsoid_edge_length_top.sv
tb/tb_nested_ellipsoid_edge_length_top.sv
